FILE: rtl/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned WordW         = 32;
  localparam int unsigned CountOutW     = 7;
  localparam int unsigned ErrW          = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

  typedef logic signed [WordW-1:0] word_t;

endpackage
`default_nettype wire

FILE: rtl/mts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface mts_in_if
  import mts_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  kind;
  word_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mts_out_if
  import mts_pkg::*;
();
  logic                 valid;
  logic                 ready;
  word_t                popped_value;
  word_t                top_value;
  word_t                min_value;
  logic [CountOutW-1:0] entry_count;
  logic                 is_empty;
  logic [ErrW-1:0]      error;

  modport source (output valid, output popped_value, output top_value, output min_value,
                  output entry_count, output is_empty, output error, input ready);
  modport sink   (input valid, input popped_value, input top_value, input min_value,
                  input entry_count, input is_empty, input error, output ready);
endinterface
`default_nettype wire

FILE: rtl/mts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ram
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module mts_ram
  import mts_pkg::*;
#(
  parameter int unsigned Depth = StackDepthDef,
  parameter int unsigned Width = WordW,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl
// Stack pointers, cached tops, memory sequencing and the result register.
// ----------------------------------------------------------------------------
module mts_ctrl
  import mts_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef,
  localparam int unsigned AddrW  = (StackDepth > 1) ? $clog2(StackDepth) : 1,
  localparam int unsigned CountW = $clog2(StackDepth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  mts_in_if.sink                in_i,
  mts_out_if.source             out_o,
  output logic                  data_we_o,
  output logic      [AddrW-1:0] data_waddr_o,
  output logic                  data_re_o,
  output logic      [AddrW-1:0] data_raddr_o,
  input  wire logic [WordW-1:0] data_rdata_i,
  output logic                  min_we_o,
  output logic      [AddrW-1:0] min_waddr_o,
  output logic                  min_re_o,
  output logic      [AddrW-1:0] min_raddr_o,
  input  wire logic [WordW-1:0] min_rdata_i,
  output word_t                 wdata_o
);

  localparam logic [CountW-1:0] DepthC = CountW'(StackDepth);
  localparam logic [CountW-1:0] OneC   = CountW'(1);
  localparam logic [CountW-1:0] TwoC   = CountW'(2);

  state_e state_q, state_d;

  logic [CountW-1:0] cnt_q, cnt_d, mcnt_q, mcnt_d;
  word_t             top_q, top_d, mtop_q, mtop_d;
  logic              reload_top_q, reload_top_d, reload_min_q, reload_min_d;
  word_t             popped_q, popped_d;
  err_e              err_q, err_d;
  logic              out_valid_q, out_valid_d;

  logic accept, load, slot_free;
  logic is_push, push_ok, min_push, pop_ok, min_pop;
  logic [CountW-1:0] data_rd_cnt, min_rd_cnt;
  logic [CountW+CountOutW-1:0] cnt_wide;

  word_t                res_popped_q, res_top_q, res_min_q;
  logic [CountOutW-1:0] res_cnt_q;
  logic                 res_empty_q;
  err_e                 res_err_q;

  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_RESP;
      ST_RESP: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_i.ready = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_RESP: load = slot_free;
      default: ;
    endcase
  end

  assign is_push  = (in_i.kind == OP_PUSH);
  assign push_ok  = is_push && (cnt_q != DepthC);
  assign min_push = push_ok && ((mcnt_q == '0) || (mtop_q >= in_i.value));
  assign pop_ok   = !is_push && (cnt_q != '0);
  assign min_pop  = pop_ok && (mcnt_q != '0) && (mtop_q == top_q);

  assign data_rd_cnt = cnt_q - TwoC;
  assign min_rd_cnt  = mcnt_q - TwoC;

  assign wdata_o      = in_i.value;
  assign data_we_o    = accept && push_ok;
  assign data_waddr_o = cnt_q[AddrW-1:0];
  assign data_re_o    = accept && pop_ok;
  assign data_raddr_o = data_rd_cnt[AddrW-1:0];
  assign min_we_o     = accept && min_push;
  assign min_waddr_o  = mcnt_q[AddrW-1:0];
  assign min_re_o     = accept && min_pop;
  assign min_raddr_o  = min_rd_cnt[AddrW-1:0];

  // Operation update and reload
  always_comb begin
    cnt_d        = cnt_q;
    mcnt_d       = mcnt_q;
    top_d        = top_q;
    mtop_d       = mtop_q;
    reload_top_d = reload_top_q;
    reload_min_d = reload_min_q;
    popped_d     = popped_q;
    err_d        = err_q;
    if (accept) begin
      reload_top_d = pop_ok && (cnt_q > OneC);
      reload_min_d = min_pop && (mcnt_q > OneC);
      popped_d     = pop_ok ? top_q : '0;
      err_d        = ERR_NONE;
      if (is_push) begin
        if (push_ok) begin
          cnt_d = cnt_q + OneC;
          top_d = in_i.value;
          if (min_push) begin
            mcnt_d = mcnt_q + OneC;
            mtop_d = in_i.value;
          end
        end else begin
          err_d = ERR_PUSH_FULL;
        end
      end else begin
        if (pop_ok) begin
          cnt_d = cnt_q - OneC;
          if (min_pop) mcnt_d = mcnt_q - OneC;
        end else begin
          err_d = ERR_POP_EMPTY;
        end
      end
    end else if (load) begin
      if (reload_top_q) top_d = data_rdata_i;
      if (reload_min_q) mtop_d = min_rdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign cnt_wide = {{CountOutW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      mcnt_q       <= '0;
      out_valid_q  <= 1'b0;
      reload_top_q <= 1'b0;
      reload_min_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      mcnt_q       <= mcnt_d;
      out_valid_q  <= out_valid_d;
      reload_top_q <= reload_top_d;
      reload_min_q <= reload_min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    mtop_q   <= mtop_d;
    popped_q <= popped_d;
    err_q    <= err_d;
    if (load) begin
      res_popped_q <= popped_q;
      res_top_q    <= (cnt_q != '0) ? top_d : '0;
      res_min_q    <= ((cnt_q != '0) && (mcnt_q != '0)) ? mtop_d : '0;
      res_cnt_q    <= cnt_wide[CountOutW-1:0];
      res_empty_q  <= (cnt_q == '0);
      res_err_q    <= err_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = res_popped_q;
  assign out_o.top_value    = res_top_q;
  assign out_o.min_value    = res_min_q;
  assign out_o.entry_count  = res_cnt_q;
  assign out_o.is_empty     = res_empty_q;
  assign out_o.error        = res_err_q;

endmodule
`default_nettype wire

FILE: rtl/min_tracking_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack of signed words that reports its current minimum.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   kind, value
//   out_o    out  valid/ready   popped_value, top_value, min_value,
//                               entry_count, is_empty, error
//
// One operation at a time, taken in the idle state: a pop reads the next top of
// the data and minimum memories through registered reads before the result forms.
// Result register lets a new operation enter while a result waits.
// Reset clears both stack pointers; memory contents need no clearing.
// A stalled result holds the block in its response state.
// ----------------------------------------------------------------------------
module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mts_in_if.sink    in_i,
  mts_out_if.source out_o
);

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic             data_we, data_re, min_we, min_re;
  logic [AddrW-1:0] data_waddr, data_raddr, min_waddr, min_raddr;
  logic [WordW-1:0] data_rdata, min_rdata;
  word_t            wdata;

  mts_ctrl #(
    .StackDepth (StackDepth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .data_we_o    (data_we),
    .data_waddr_o (data_waddr),
    .data_re_o    (data_re),
    .data_raddr_o (data_raddr),
    .data_rdata_i (data_rdata),
    .min_we_o     (min_we),
    .min_waddr_o  (min_waddr),
    .min_re_o     (min_re),
    .min_raddr_o  (min_raddr),
    .min_rdata_i  (min_rdata),
    .wdata_o      (wdata)
  );

  mts_ram #(
    .Depth (StackDepth),
    .Width (WordW)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (wdata),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  mts_ram #(
    .Depth (StackDepth),
    .Width (WordW)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (min_waddr),
    .wdata_i (wdata),
    .re_i    (min_re),
    .raddr_i (min_raddr),
    .rdata_o (min_rdata)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the minimum-tracking stack. A directed table covers
// reset, empty and full errors, signed extremes and duplicate minima; a long
// run of push-heavy, pop-heavy and mixed bursts follows. Each result is
// checked against a stack model kept in the bench, with random idling on
// the input channel and random back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb;
  import mts_pkg::*;

  localparam int unsigned Depth         = StackDepthDef;
  localparam int unsigned NumDirRows    = 25;
  localparam int unsigned RandItems     = 1800;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    word_t                popped_value;
    word_t                top_value;
    word_t                min_value;
    logic [CountOutW-1:0] entry_count;
    logic                 is_empty;
    err_e                 error;
  } stack_result_t;

  typedef struct {
    op_e           kind;
    word_t         value;
    int unsigned   reps;
    bit            fixed;
    stack_result_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mts_in_if  in_if ();
  mts_out_if out_if ();

  min_tracking_stack_top #(
    .StackDepth(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  word_t         data_mem [Depth];
  word_t         min_mem  [Depth];
  int unsigned   data_cnt;
  int unsigned   min_cnt;
  stack_result_t expected_q [$];
  int unsigned   fail_count;
  int unsigned   mismatch_count;
  int unsigned   tx_gap_max;
  dir_row_t      dir_tab [NumDirRows];

  function automatic stack_result_t mk_res(word_t pop_v, word_t top_v, word_t min_v,
                                           int unsigned cnt, logic empty, err_e err);
    stack_result_t r;
    r.popped_value = pop_v;
    r.top_value    = top_v;
    r.min_value    = min_v;
    r.entry_count  = CountOutW'(cnt);
    r.is_empty     = empty;
    r.error        = err;
    return r;
  endfunction

  function automatic stack_result_t apply_stack_op(op_e k, word_t v);
    stack_result_t r;
    r = '0;
    r.error = ERR_NONE;
    if (k == OP_PUSH) begin
      if (data_cnt >= Depth) begin
        r.error = ERR_PUSH_FULL;
      end else begin
        data_mem[data_cnt] = v;
        data_cnt++;
        if (min_cnt == 0 || min_mem[min_cnt-1] >= v) begin
          if (min_cnt < Depth) begin
            min_mem[min_cnt] = v;
            min_cnt++;
          end
        end
      end
    end else begin
      if (data_cnt == 0) begin
        r.error = ERR_POP_EMPTY;
      end else begin
        data_cnt--;
        r.popped_value = data_mem[data_cnt];
        if (min_cnt > 0 && min_mem[min_cnt-1] == r.popped_value) min_cnt--;
      end
    end
    r.top_value   = (data_cnt > 0) ? data_mem[data_cnt-1] : '0;
    r.min_value   = (data_cnt > 0 && min_cnt > 0) ? min_mem[min_cnt-1] : '0;
    r.entry_count = CountOutW'(data_cnt);
    r.is_empty    = (data_cnt == 0);
    return r;
  endfunction

  function automatic string fmt_res(stack_result_t r);
    return $sformatf("pop=%h top=%h min=%h cnt=%0d empty=%b err=%0d",
                     r.popped_value, r.top_value, r.min_value, r.entry_count,
                     r.is_empty, r.error);
  endfunction

  function automatic word_t pick_value();
    int unsigned mode;
    word_t       v;
    mode = $urandom_range(0, 9);
    case (mode)
      4, 5: v = word_t'(int'($urandom_range(0, 8)) - 4);
      6: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      7: v = (min_cnt > 0) ? min_mem[min_cnt-1] : word_t'($urandom);
      8: v = (min_cnt > 0) ? min_mem[min_cnt-1] + word_t'(int'($urandom_range(0, 2)) - 1)
                           : word_t'($urandom);
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_op(input op_e k, input word_t v, input bit fixed,
                         input stack_result_t lit);
    int unsigned   gap;
    stack_result_t exp_r;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= k;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    exp_r = apply_stack_op(k, v);
    if (fixed) exp_r = lit;
    expected_q.push_back(exp_r);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned push_pct;
    bit          paused_mid;
    op_e         k;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = OP_PUSH;
    in_if.value    = '0;
    data_cnt       = 0;
    min_cnt        = 0;
    fail_count     = 0;
    mismatch_count = 0;
    tx_gap_max     = 10;
    paused_mid     = 1'b0;
    sent           = 0;

    dir_tab = '{
      '{OP_POP,  32'sh0000_0000, 1, 1'b1, mk_res(0, 0, 0, 0, 1'b1, ERR_POP_EMPTY)},
      '{OP_POP,  32'sh1234_5678, 1, 1'b1, mk_res(0, 0, 0, 0, 1'b1, ERR_POP_EMPTY)},
      '{OP_PUSH, 32'sh7fff_ffff, 1, 1'b1,
        mk_res(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1'b0, ERR_NONE)},
      '{OP_PUSH, 32'sh8000_0000, 1, 1'b1,
        mk_res(0, 32'sh8000_0000, 32'sh8000_0000, 2, 1'b0, ERR_NONE)},
      '{OP_PUSH, 32'sh8000_0000, 1, 1'b1,
        mk_res(0, 32'sh8000_0000, 32'sh8000_0000, 3, 1'b0, ERR_NONE)},
      '{OP_PUSH, 32'sh0000_0000, 1, 1'b1, mk_res(0, 0, 32'sh8000_0000, 4, 1'b0, ERR_NONE)},
      '{OP_PUSH, 32'shffff_ffff, 1, 1'b1,
        mk_res(0, 32'shffff_ffff, 32'sh8000_0000, 5, 1'b0, ERR_NONE)},
      '{OP_POP,  32'shffff_ffff, 1, 1'b1,
        mk_res(32'shffff_ffff, 0, 32'sh8000_0000, 4, 1'b0, ERR_NONE)},
      '{OP_POP,  32'sh0000_0000, 1, 1'b1,
        mk_res(0, 32'sh8000_0000, 32'sh8000_0000, 3, 1'b0, ERR_NONE)},
      '{OP_POP,  32'sh0000_0000, 1, 1'b1,
        mk_res(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 2, 1'b0, ERR_NONE)},
      '{OP_POP,  32'sh0000_0000, 1, 1'b1,
        mk_res(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1'b0, ERR_NONE)},
      '{OP_POP,  32'sh0000_0000, 1, 1'b1, mk_res(32'sh7fff_ffff, 0, 0, 0, 1'b1, ERR_NONE)},
      '{OP_POP,  32'shffff_ffff, 1, 1'b1, mk_res(0, 0, 0, 0, 1'b1, ERR_POP_EMPTY)},
      '{OP_PUSH, 32'sh0000_0005, 1, 1'b0, '0},
      '{OP_PUSH, 32'sh0000_0003, 1, 1'b0, '0},
      '{OP_PUSH, 32'sh0000_0003, 1, 1'b0, '0},
      '{OP_PUSH, 32'sh0000_0007, 1, 1'b0, '0},
      '{OP_POP,  32'sh0000_0000, 1, 1'b0, '0},
      '{OP_POP,  32'sh0000_0000, 1, 1'b0, '0},
      '{OP_POP,  32'sh0000_0000, 1, 1'b0, '0},
      '{OP_PUSH, 32'sh5a5a_5a5a, Depth - 1, 1'b0, '0},
      '{OP_PUSH, 32'sha5a5_a5a5, 1, 1'b1,
        mk_res(0, 32'sh5a5a_5a5a, 32'sh0000_0005, Depth, 1'b0, ERR_PUSH_FULL)},
      '{OP_PUSH, 32'sh8000_0000, 1, 1'b1,
        mk_res(0, 32'sh5a5a_5a5a, 32'sh0000_0005, Depth, 1'b0, ERR_PUSH_FULL)},
      '{OP_POP,  32'sh0000_0000, Depth, 1'b0, '0},
      '{OP_POP,  32'sh7fff_ffff, 1, 1'b1, mk_res(0, 0, 0, 0, 1'b1, ERR_POP_EMPTY)}
    };

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      for (int unsigned r = 0; r < dir_tab[i].reps; r++) begin
        send_op(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].fixed, dir_tab[i].res);
      end
    end
    wait_drain();

    while (sent < RandItems) begin
      phase      = $urandom_range(0, 3);
      phase_len  = $urandom_range(20, 150);
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      case (phase)
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(0, 100);
      endcase
      for (int unsigned i = 0; i < phase_len && sent < RandItems; i++) begin
        if (!paused_mid && sent == RandItems / 2) begin
          wait_drain();
          paused_mid = 1'b1;
        end
        k = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_op(k, pick_value(), 1'b0, '0);
        sent++;
      end
    end

    wait_drain();
    repeat (16) @(posedge clk_i);
    if (expected_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned   hold;
    int unsigned   got;
    int unsigned   rx_gap_max;
    stack_result_t act;
    stack_result_t exp_r;

    got          = 0;
    rx_gap_max   = 10;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (got % 50 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      if (got == 200 || got == 1200) begin
        hold = 300;
      end else begin
        hold = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      act.popped_value = out_if.popped_value;
      act.top_value    = out_if.top_value;
      act.min_value    = out_if.min_value;
      act.entry_count  = out_if.entry_count;
      act.is_empty     = out_if.is_empty;
      act.error        = err_e'(out_if.error);
      got++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (mismatch_count < MaxReports) begin
          $display("result %0d with nothing expected: %s", got, fmt_res(act));
        end
        mismatch_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (act.popped_value !== exp_r.popped_value || act.top_value !== exp_r.top_value ||
            act.min_value !== exp_r.min_value || act.entry_count !== exp_r.entry_count ||
            act.is_empty !== exp_r.is_empty || act.error !== exp_r.error) begin
          fail_count++;
          if (mismatch_count < MaxReports) begin
            $display("result %0d mismatch\n  exp %s\n  got %s", got, fmt_res(exp_r),
                     fmt_res(act));
          end
          mismatch_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
